FILE: sv/i2c_eeprom_transfer_sequencer_unit_macros.svh
// Assertion macros for the transfer sequencer modules.
// Depends on nothing; included by modules that assert.
`ifndef I2C_EEPROM_TRANSFER_SEQUENCER_UNIT_MACROS_SVH
`define I2C_EEPROM_TRANSFER_SEQUENCER_UNIT_MACROS_SVH
// Assert that a property holds on every clock edge outside reset.
`define ETS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that an implication holds on every clock edge outside reset.
`define ETS_IMPLY(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`endif

FILE: sv/ets_pkg.sv
// Package for the EEPROM transfer sequencer: operation codes, result kinds,
// status codes, register indices, and the queue entry and result types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ets_pkg;
    localparam logic [1:0] OP_BEGIN_WRITE = 2'd0;
    localparam logic [1:0] OP_BEGIN_READ  = 2'd1;
    localparam logic [1:0] OP_DATA        = 2'd2;
    localparam logic [1:0] OP_REPLY       = 2'd3;

    localparam logic [3:0] K_START     = 4'd0;
    localparam logic [3:0] K_RSTART    = 4'd1;
    localparam logic [3:0] K_SEND      = 4'd2;
    localparam logic [3:0] K_RECV_ACK  = 4'd3;
    localparam logic [3:0] K_RECV_NACK = 4'd4;
    localparam logic [3:0] K_STOP      = 4'd5;
    localparam logic [3:0] K_WAIT      = 4'd6;
    localparam logic [3:0] K_DATA      = 4'd7;
    localparam logic [3:0] K_DONE      = 4'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_ADDR     = 2'd2;
    localparam logic [1:0] ST_NACK     = 2'd3;

    localparam logic REG_DEV = 1'b0;
    localparam logic REG_TWO = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] mem_address;
        logic [15:0] length;
        logic [7:0]  data_byte;
        logic        bus_ack;
        logic [7:0]  bus_byte;
    } item_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] bus_value;
        logic [1:0] status;
        logic       last;
    } result_t;
endpackage
`default_nettype wire

FILE: sv/ets_front.sv
// Front part: a four-entry queue that accepts input items and holds them for the back part.
// Depends on ets_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ets_front
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  wire ets_pkg::item_t in_item,
    output logic           q_valid,
    input  wire            q_ready,
    output ets_pkg::item_t q_item
);
    import ets_pkg::*;
    localparam int DEPTH = 4;
    item_t     mem_reg [DEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != 3'(DEPTH));
    assign q_valid  = (cnt_reg != 3'd0);
    assign q_item   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end
endmodule
`default_nettype wire

FILE: sv/ets_back.sv
// Back part: runs the bus sequencer for one queued item, emitting up to four
// results one per cycle while out_ready is high. Depends on ets_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_eeprom_transfer_sequencer_unit_macros.svh"
module ets_back
#(
    parameter int PAGE_BYTES = 32,
    parameter int MEM_BYTES  = 4096
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              q_valid,
    output logic             q_ready,
    input  wire ets_pkg::item_t q_item,
    input  wire  [7:0]       dev_addr,
    input  wire              two_byte,
    output logic             out_valid,
    input  wire              out_ready,
    output ets_pkg::result_t out_res
);
    import ets_pkg::*;
    localparam int PW = $clog2(PAGE_BYTES);

    localparam logic [3:0] PH_IDLE = 4'd0, PH_START = 4'd1, PH_DEV = 4'd2,
        PH_HIGH = 4'd3, PH_LOW = 4'd4, PH_DWAIT = 4'd5, PH_DACK = 4'd6,
        PH_SKIP = 4'd7, PH_RECV = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] addr_reg, addr_next, rem_reg, rem_next;
    logic [8:0]  pleft_reg, pleft_next;
    logic [1:0]  tst_reg, tst_next;
    logic        rd_reg, rd_next;

    // Result buffer: the results of one item, drained one per cycle while out_ready is high.
    result_t     buf_reg [4];
    logic [2:0]  bcnt_reg, bidx_reg;
    result_t     nb [4];
    logic [2:0]  n;
    logic        take;

    assign q_ready   = (bidx_reg == bcnt_reg) || (out_ready && bidx_reg + 3'd1 == bcnt_reg);
    assign take      = q_valid && q_ready;
    assign out_valid = (bidx_reg != bcnt_reg);
    assign out_res   = buf_reg[bidx_reg[1:0]];

    function automatic logic [8:0] min_room(input logic [15:0] a, input logic [15:0] r);
        logic [9:0] room;
        room = 10'(PAGE_BYTES) - 10'(a[PW-1:0]);
        min_room = (17'(room) > 17'(r)) ? r[8:0] : room[8:0];
    endfunction

    always_comb
    begin
        logic [16:0] sum;
        logic [15:0] a1, r1;
        logic [8:0]  p1;
        phase_next = phase_reg; addr_next = addr_reg; rem_next = rem_reg;
        pleft_next = pleft_reg; tst_next = tst_reg; rd_next = rd_reg;
        n = 3'd0;
        for (int i = 0; i < 4; i++) nb[i] = '0;
        sum = 17'(q_item.mem_address) + 17'(q_item.length);
        a1 = addr_reg + 16'd1;
        r1 = (rem_reg != 16'd0) ? rem_reg - 16'd1 : rem_reg;
        p1 = (pleft_reg != 9'd0) ? pleft_reg - 9'd1 : pleft_reg;
        case (q_item.operation)
            OP_BEGIN_WRITE, OP_BEGIN_READ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    addr_next = q_item.mem_address; rem_next = q_item.length;
                    tst_next = ST_OK; rd_next = (q_item.operation == OP_BEGIN_READ);
                    if (q_item.operation == OP_BEGIN_READ)
                    begin
                        nb[0].kind = K_START; n = 3'd1; phase_next = PH_START;
                    end
                    else if (sum > 17'(MEM_BYTES))
                    begin
                        nb[0].kind = K_DONE; nb[0].status = ST_RANGE; n = 3'd1;
                    end
                    else if (q_item.length == 16'd0)
                    begin
                        nb[0].kind = K_DONE; n = 3'd1;
                    end
                    else
                    begin
                        pleft_next = min_room(q_item.mem_address, q_item.length);
                        nb[0].kind = K_START; n = 3'd1; phase_next = PH_START;
                    end
                end
            end
            OP_DATA:
            begin
                if (phase_reg == PH_DWAIT)
                begin
                    nb[0].kind = K_SEND; nb[0].bus_value = q_item.data_byte; n = 3'd1;
                    phase_next = PH_DACK;
                end
                else if (phase_reg == PH_SKIP)
                begin
                    addr_next = a1; rem_next = r1; pleft_next = p1;
                    if (p1 == 9'd0)
                    begin
                        n = 3'd1;
                        if (r1 != 16'd0)
                        begin
                            nb[0].kind = K_START; pleft_next = min_room(a1, r1);
                            phase_next = PH_START;
                        end
                        else
                        begin
                            nb[0].kind = K_DONE; nb[0].status = tst_reg;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                case (phase_reg)
                    PH_START, PH_DEV, PH_HIGH, PH_LOW:
                    begin
                        if (!q_item.bus_ack)
                        begin
                            if (rd_reg)
                            begin
                                nb[0].kind = K_STOP; nb[1].kind = K_DONE;
                                nb[1].status = ST_ADDR; n = 3'd2;
                            end
                            else
                            begin
                                nb[0].kind = K_DONE; nb[0].status = ST_ADDR; n = 3'd1;
                            end
                            phase_next = PH_IDLE;
                        end
                        else if (phase_reg == PH_START)
                        begin
                            nb[0].kind = K_SEND; nb[0].bus_value = dev_addr; n = 3'd1;
                            phase_next = PH_DEV;
                        end
                        else if (phase_reg == PH_DEV)
                        begin
                            nb[0].kind = K_SEND; n = 3'd1;
                            nb[0].bus_value = two_byte ? addr_reg[15:8] : addr_reg[7:0];
                            phase_next = two_byte ? PH_HIGH : PH_LOW;
                        end
                        else if (phase_reg == PH_HIGH)
                        begin
                            nb[0].kind = K_SEND; nb[0].bus_value = addr_reg[7:0]; n = 3'd1;
                            phase_next = PH_LOW;
                        end
                        else if (rd_reg)
                        begin
                            nb[0].kind = K_RSTART; nb[1].kind = K_SEND;
                            nb[1].bus_value = dev_addr | 8'h01; n = 3'd3;
                            if (rem_reg != 16'd0)
                            begin
                                nb[2].kind = (rem_reg > 16'd1) ? K_RECV_ACK : K_RECV_NACK;
                                phase_next = PH_RECV;
                            end
                            else
                            begin
                                nb[2].kind = K_STOP; nb[3].kind = K_DONE; n = 3'd4;
                                phase_next = PH_IDLE;
                            end
                        end
                        else
                        begin
                            phase_next = PH_DWAIT;
                        end
                    end
                    PH_DACK:
                    begin
                        addr_next = a1; rem_next = r1; pleft_next = p1;
                        if (q_item.bus_ack && p1 != 9'd0)
                        begin
                            phase_next = PH_DWAIT;
                        end
                        else
                        begin
                            nb[0].kind = K_STOP; nb[1].kind = K_WAIT; n = 3'd2;
                            if (!q_item.bus_ack) tst_next = ST_NACK;
                            if (p1 != 9'd0)
                            begin
                                phase_next = PH_SKIP;
                            end
                            else if (r1 != 16'd0)
                            begin
                                nb[2].kind = K_START; n = 3'd3;
                                pleft_next = min_room(a1, r1); phase_next = PH_START;
                            end
                            else
                            begin
                                nb[2].kind = K_DONE; n = 3'd3;
                                nb[2].status = q_item.bus_ack ? tst_reg : ST_NACK;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_RECV:
                    begin
                        nb[0].kind = K_DATA; nb[0].bus_value = q_item.bus_byte; n = 3'd2;
                        addr_next = a1; rem_next = r1;
                        if (r1 != 16'd0)
                        begin
                            nb[1].kind = (r1 > 16'd1) ? K_RECV_ACK : K_RECV_NACK;
                        end
                        else
                        begin
                            nb[1].kind = K_STOP; nb[2].kind = K_DONE;
                            nb[2].status = tst_reg; n = 3'd3; phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase
        if (n != 3'd0) nb[2'(n - 3'd1)].last = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 4; i++) buf_reg[i] <= nb[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; addr_reg <= '0; rem_reg <= '0; pleft_reg <= '0;
            tst_reg <= '0; rd_reg <= 1'b0; bcnt_reg <= '0; bidx_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next; addr_reg <= addr_next; rem_reg <= rem_next;
            pleft_reg <= pleft_next; tst_reg <= tst_next; rd_reg <= rd_next;
            bcnt_reg <= n; bidx_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            bidx_reg <= bidx_reg + 3'd1;
        end
    end

    `ETS_ASSERT(a_idx_le_cnt, clk, rst_n, (bidx_reg <= bcnt_reg), "index past count")
    `ETS_IMPLY(a_last_end, clk, rst_n, out_valid && out_res.last, bidx_reg + 3'd1 == bcnt_reg,
        "last not on final result")
    `ETS_IMPLY(a_take_free, clk, rst_n, take,
        (bidx_reg == bcnt_reg) || (out_valid && out_ready && bidx_reg + 3'd1 == bcnt_reg),
        "item taken over pending results")
endmodule
`default_nettype wire

FILE: sv/i2c_eeprom_transfer_sequencer_unit.sv
// EEPROM transfer sequencer. Items are accepted while the input queue has
// room; the results of an item (up to four) leave one per cycle while
// m_axis_tready is high, through the input queue, then the result buffer.
// A four-entry queue parts acceptance from the sequencer; drain of results
// sets the rate when an item yields several. Reset is asynchronous, active
// low, and returns the sequencer to idle with the registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
module i2c_eeprom_transfer_sequencer_unit
#(
    parameter int PAGE_BYTES = 32,
    parameter int MEM_BYTES  = 4096
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [1:0]  s_axis_tuser,  // operation
    input  wire  [55:0] s_axis_tdata,  // mem_address, length, data_byte, bus_ack, bus_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // kind, bus_value, status
    output logic        m_axis_tlast,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [7:0]  cfg_data
);
    import ets_pkg::*;
    item_t   in_item, q_item;
    result_t res;
    logic    q_valid, q_ready;
    logic [7:0] dev_reg;
    logic       two_reg;

    assign in_item.operation   = s_axis_tuser;
    assign in_item.mem_address = s_axis_tdata[15:0];
    assign in_item.length      = s_axis_tdata[31:16];
    assign in_item.data_byte   = s_axis_tdata[39:32];
    assign in_item.bus_ack     = s_axis_tdata[40];
    assign in_item.bus_byte    = s_axis_tdata[48:41];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg <= 8'd160;
            two_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DEV) dev_reg <= cfg_data;
            else two_reg <= cfg_data[0];
        end
    end

    ets_front u_front (.clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready), .in_item(in_item), .q_valid(q_valid),
        .q_ready(q_ready), .q_item(q_item));

    ets_back #(.PAGE_BYTES(PAGE_BYTES), .MEM_BYTES(MEM_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .dev_addr(dev_reg), .two_byte(two_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res));

    assign m_axis_tdata = {2'b00, res.status, res.bus_value, res.kind};
    assign m_axis_tlast = res.last;
endmodule
`default_nettype wire
